[rtl/hyperplane_lsh_probe_signatures_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the hyperplane LSH probe signature unit
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef HYPERPLANE_LSH_PROBE_SIGNATURES_UNIT_ASSERT_SVH
`define HYPERPLANE_LSH_PROBE_SIGNATURES_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define HLSH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define HLSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hlsh_pkg.sv]
// ----------------------------------------------------------------------------
// hlsh_pkg
// Shared types and constants of the hyperplane LSH probe signature unit.
// ----------------------------------------------------------------------------
package hlsh_pkg;

    // Fixed field widths
    localparam int ACC_WIDTH   = 48;
    localparam int SIG_WIDTH   = 15;
    localparam int PLANE_WIDTH = 4;
    localparam int ELEM_WIDTH  = 10;
    localparam int DIM_WIDTH   = 11;
    localparam int NB_WIDTH    = 4;

    // Request modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_VECTOR = 1'b1;

    // Register indexes (paddr bit 2)
    localparam logic REG_DIMENSION = 1'b0;
    localparam logic REG_NUM_BITS  = 1'b1;

    // Register reset values
    localparam logic [DIM_WIDTH-1:0] DIMENSION_RESET = 11'd128;
    localparam logic [NB_WIDTH-1:0]  NUM_BITS_RESET  = 4'd8;

    // Control travelling from cell to cell with each request
    typedef struct packed {
        logic                   load;   // coefficient write
        logic                   acc;    // vector element to accumulate
        logic                   first;  // element zero, clear sums
        logic                   done;   // final element of the vector
        logic [PLANE_WIDTH-1:0] plane;
        logic [ELEM_WIDTH-1:0]  elem;
    } cell_ctrl_t;

endpackage

[rtl/hlsh_ram.sv]
// ----------------------------------------------------------------------------
// hlsh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hlsh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/hlsh_cell.sv]
// ----------------------------------------------------------------------------
// hlsh_cell
// One hyperplane: coefficient RAM, multiplier, 48-bit sum and sign bit.
// Requests hop to the next cell each cycle; product, sum and sign registers follow.
// ----------------------------------------------------------------------------
module hlsh_cell #(
    parameter int PLANE_ID     = 0,
    parameter int MAX_DIM      = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [hlsh_pkg::NB_WIDTH-1:0]        num_planes,
    input  hlsh_pkg::cell_ctrl_t                 ctrl_in,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
    input  logic [hlsh_pkg::SIG_WIDTH-1:0]       sig_in,
    output hlsh_pkg::cell_ctrl_t                 ctrl_out,
    output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
    output logic [hlsh_pkg::SIG_WIDTH-1:0]       sig_out,
    output logic                                 sig_done
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    hlsh_pkg::cell_ctrl_t                   ctrl_out_reg;
    logic signed [SAMPLE_WIDTH-1:0]         sample_out_reg;
    logic signed [SAMPLE_WIDTH-1:0]         coef;
    logic signed [2*SAMPLE_WIDTH-1:0]       prod_full;
    logic [hlsh_pkg::ACC_WIDTH-1:0]         prod_reg;
    logic                                   c_acc_reg;
    logic                                   c_first_reg;
    logic                                   c_done_reg;
    logic [hlsh_pkg::ACC_WIDTH-1:0]         acc_reg;
    logic [hlsh_pkg::ACC_WIDTH-1:0]         acc_next;
    logic                                   d_done_reg;
    logic                                   plane_bit;
    logic [hlsh_pkg::SIG_WIDTH-1:0]         sig_out_reg;
    logic [hlsh_pkg::SIG_WIDTH-1:0]         sig_out_next;
    logic                                   sig_done_reg;
    logic                                   wr_en;
    logic [AW-1:0]                          addr;

    // Coefficient store of this plane
    assign addr  = AW'(ctrl_in.elem);
    assign wr_en = ctrl_in.load && (ctrl_in.plane == hlsh_pkg::PLANE_WIDTH'(PLANE_ID));

    hlsh_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_DIM)
    ) u_coef_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (sample_in),
        .rd_en   (ctrl_in.acc),
        .rd_addr (addr),
        .rd_data (coef)
    );

    // Hand the request on to the neighbour
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_out_reg <= '0;
        end else begin
            ctrl_out_reg <= ctrl_in;
        end
        sample_out_reg <= sample_in;
    end

    // Multiply element by coefficient
    assign prod_full = sample_out_reg * coef;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_acc_reg   <= 1'b0;
            c_first_reg <= 1'b0;
            c_done_reg  <= 1'b0;
        end else begin
            c_acc_reg   <= ctrl_out_reg.acc;
            c_first_reg <= ctrl_out_reg.first;
            c_done_reg  <= ctrl_out_reg.done;
        end
        prod_reg <= hlsh_pkg::ACC_WIDTH'(prod_full);
    end

    // Accumulate, clearing on element zero; wraps modulo 2^48
    assign acc_next = (c_first_reg ? '0 : acc_reg) + prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            d_done_reg <= 1'b0;
        end else begin
            if (c_acc_reg) begin
                acc_reg <= acc_next;
            end
            d_done_reg <= c_done_reg;
        end
    end

    // Add this plane's sign bit to the passing signature
    assign plane_bit = (acc_reg != '0) && !acc_reg[hlsh_pkg::ACC_WIDTH-1]
                       && (hlsh_pkg::NB_WIDTH'(PLANE_ID) < num_planes);
    assign sig_out_next = sig_in | (hlsh_pkg::SIG_WIDTH'(plane_bit) << PLANE_ID);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_done_reg <= 1'b0;
        end else begin
            sig_done_reg <= d_done_reg;
        end
        sig_out_reg <= sig_out_next;
    end

    assign ctrl_out   = ctrl_out_reg;
    assign sample_out = sample_out_reg;
    assign sig_out    = sig_out_reg;
    assign sig_done   = sig_done_reg;

endmodule

[rtl/hlsh_emit.sv]
// ----------------------------------------------------------------------------
// hlsh_emit
// Signature queue and probe expansion onto the result channel, with credit
// tracking of finished vectors still in the cell chain or the queue.
// ----------------------------------------------------------------------------
module hlsh_emit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [hlsh_pkg::NB_WIDTH-1:0]     num_planes,
    input  logic                              vec_started,
    output logic                              credit_ok,
    input  logic                              push,
    input  logic [hlsh_pkg::SIG_WIDTH-1:0]    push_sig,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [hlsh_pkg::SIG_WIDTH-1:0]    m_signature,
    output logic [hlsh_pkg::NB_WIDTH-1:0]     m_probe_index,
    output logic                              m_last_probe
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [hlsh_pkg::SIG_WIDTH-1:0] fifo_reg [DEPTH];
    logic [PW-1:0]                  wr_ptr_reg;
    logic [PW-1:0]                  rd_ptr_reg;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic [CW-1:0]                  pending_reg;
    logic [CW-1:0]                  pending_next;
    logic [hlsh_pkg::NB_WIDTH-1:0]  probe_reg;
    logic [hlsh_pkg::SIG_WIDTH-1:0] head;
    logic [hlsh_pkg::SIG_WIDTH-1:0] probe_sig;
    logic                           load;
    logic                           is_last;
    logic                           pop;
    logic                           m_valid_reg;
    logic [hlsh_pkg::SIG_WIDTH-1:0] m_signature_reg;
    logic [hlsh_pkg::NB_WIDTH-1:0]  m_probe_index_reg;
    logic                           m_last_probe_reg;

    // Next probe from the queue head
    assign head      = fifo_reg[rd_ptr_reg];
    assign load      = (count_reg != '0) && (!m_valid_reg || m_ready);
    assign is_last   = (probe_reg == num_planes);
    assign pop       = load && is_last;
    assign probe_sig = (probe_reg == '0) ? head
                     : head ^ (hlsh_pkg::SIG_WIDTH'(1) << (probe_reg - 4'd1));

    assign count_next   = count_reg + CW'(push) - CW'(pop);
    assign pending_next = pending_reg + CW'(vec_started) - CW'(pop);
    assign credit_ok    = (pending_reg < CW'(DEPTH));

    // Queue pointers, credit and probe counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            pending_reg <= '0;
            probe_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg   <= count_next;
            pending_reg <= pending_next;
            if (load) begin
                probe_reg   <= is_last ? '0 : probe_reg + hlsh_pkg::NB_WIDTH'(1);
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Queue storage and output payload
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= push_sig;
        end
        if (load) begin
            m_signature_reg   <= probe_sig;
            m_probe_index_reg <= probe_reg;
            m_last_probe_reg  <= is_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_signature   = m_signature_reg;
    assign m_probe_index = m_probe_index_reg;
    assign m_last_probe  = m_last_probe_reg;

endmodule

[rtl/hyperplane_lsh_probe_signatures_unit.sv]
// ----------------------------------------------------------------------------
// hyperplane_lsh_probe_signatures_unit
// Random-hyperplane LSH probe signature generator: a chain of plane cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per accepted cycle. Mode 0 writes one coefficient
//   of one plane; mode 1 carries one vector element. Each element hops from
//   cell to cell, one plane per cell, so the chain takes a request every cycle.
//   m_ channel: when the element at index dimension-1 completes, the exact
//   signature (probe 0) and then one probe per plane with that bit flipped
//   come out, one a cycle; the final one carries m_last_probe.
//   The first result follows the final accepted element through one hop per
//   cell, then the multiply, sum, sign and queue registers.
//   Throughput: one request per cycle; a finished vector gives num_bits + 1
//   results at one per cycle, num_bits taken within 2..MAX_PLANES. Up to four
//   finished signatures may be queued or in flight; s_ready drops while four
//   are outstanding.
//   A stall on m_ready holds the result register and fills the queue; the
//   chain keeps running until the credit runs out.
//   Reset clears sums, queue and registers (dimension 128, num_bits 8);
//   coefficient RAMs hold nothing valid until written.
//   APB: dimension at 0x0, num_bits at 0x4; write only while idle.
// ----------------------------------------------------------------------------
module hyperplane_lsh_probe_signatures_unit #(
    parameter int MAX_DIM      = 1024,
    parameter int MAX_PLANES   = 15,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [2:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    // Request channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_mode,
    input  logic [hlsh_pkg::PLANE_WIDTH-1:0]        s_plane_index,
    input  logic [hlsh_pkg::ELEM_WIDTH-1:0]         s_element_index,
    input  logic signed [SAMPLE_WIDTH-1:0]          s_sample_value,
    // Result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [hlsh_pkg::SIG_WIDTH-1:0]          m_signature,
    output logic [hlsh_pkg::NB_WIDTH-1:0]           m_probe_index,
    output logic                                    m_last_probe
);

    logic [hlsh_pkg::DIM_WIDTH-1:0] dimension_reg;
    logic [hlsh_pkg::NB_WIDTH-1:0]  num_bits_reg;
    logic [hlsh_pkg::NB_WIDTH-1:0]  num_planes;
    logic                           cfg_write;
    logic                           accept;
    logic                           elem_in_dim;
    logic                           elem_in_max;
    hlsh_pkg::cell_ctrl_t           entry;

    hlsh_pkg::cell_ctrl_t           ctrl_link   [MAX_PLANES+1];
    logic signed [SAMPLE_WIDTH-1:0] sample_link [MAX_PLANES+1];
    logic [hlsh_pkg::SIG_WIDTH-1:0] sig_link    [MAX_PLANES+1];
    logic                           done_link   [MAX_PLANES];

    // Register writes
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dimension_reg <= hlsh_pkg::DIMENSION_RESET;
            num_bits_reg  <= hlsh_pkg::NUM_BITS_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                hlsh_pkg::REG_DIMENSION: dimension_reg <= pwdata[hlsh_pkg::DIM_WIDTH-1:0];
                hlsh_pkg::REG_NUM_BITS:  num_bits_reg  <= pwdata[hlsh_pkg::NB_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[2])
            hlsh_pkg::REG_DIMENSION: prdata = 32'(dimension_reg);
            hlsh_pkg::REG_NUM_BITS:  prdata = 32'(num_bits_reg);
            default:                 prdata = '0;
        endcase
    end

    // Clamp plane count to the supported range
    always_comb begin
        if (num_bits_reg < 4'd2) begin
            num_planes = 4'd2;
        end else if (32'(num_bits_reg) > MAX_PLANES) begin
            num_planes = hlsh_pkg::NB_WIDTH'(MAX_PLANES);
        end else begin
            num_planes = num_bits_reg;
        end
    end

    // Classify the incoming request
    assign accept      = s_valid && s_ready;
    assign elem_in_dim = {1'b0, s_element_index} < dimension_reg;
    assign elem_in_max = 32'(s_element_index) < MAX_DIM;

    always_comb begin
        entry.load  = accept && (s_mode == hlsh_pkg::MODE_LOAD)
                      && (32'(s_plane_index) < MAX_PLANES) && elem_in_max;
        entry.acc   = accept && (s_mode == hlsh_pkg::MODE_VECTOR)
                      && elem_in_dim && elem_in_max;
        entry.first = (s_element_index == '0);
        entry.done  = entry.acc
                      && (({1'b0, s_element_index} + 11'd1) == dimension_reg);
        entry.plane = s_plane_index;
        entry.elem  = s_element_index;
    end

    assign ctrl_link[0]   = entry;
    assign sample_link[0] = s_sample_value;
    assign sig_link[0]    = '0;

    // Chain of plane cells
    for (genvar p = 0; p < MAX_PLANES; p++) begin : g_cell
        hlsh_cell #(
            .PLANE_ID     (p),
            .MAX_DIM      (MAX_DIM),
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .num_planes (num_planes),
            .ctrl_in    (ctrl_link[p]),
            .sample_in  (sample_link[p]),
            .sig_in     (sig_link[p]),
            .ctrl_out   (ctrl_link[p+1]),
            .sample_out (sample_link[p+1]),
            .sig_out    (sig_link[p+1]),
            .sig_done   (done_link[p])
        );
    end

    // Queue and probe expansion
    hlsh_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .num_planes    (num_planes),
        .vec_started   (entry.done),
        .credit_ok     (s_ready),
        .push          (done_link[MAX_PLANES-1]),
        .push_sig      (sig_link[MAX_PLANES]),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_signature   (m_signature),
        .m_probe_index (m_probe_index),
        .m_last_probe  (m_last_probe)
    );

endmodule

[rtl/hlsh_checker.sv]
// ----------------------------------------------------------------------------
// hlsh_checker
// Port-level checks of the probe signature unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "hyperplane_lsh_probe_signatures_unit_assert.svh"

module hlsh_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [hlsh_pkg::SIG_WIDTH-1:0]    m_signature,
    input logic [hlsh_pkg::NB_WIDTH-1:0]     m_probe_index,
    input logic                              m_last_probe,
    input logic                              pready
);

    // Hold a stalled result
    `HLSH_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_signature) && $stable(m_probe_index), "stalled result changed")

    // Probes of one run follow back to back in order
    `HLSH_ASSERT_NEXT(a_run, m_valid && m_ready && !m_last_probe, m_valid && (m_probe_index == $past(m_probe_index) + 4'd1), "probe run broken")

    // Exact signature never ends a run
    `HLSH_ASSERT_SAME(a_exact, m_valid && (m_probe_index == 4'd0), !m_last_probe, "exact signature flagged last")

    // Register port never waits
    `HLSH_ASSERT_SAME(a_pready, 1'b1, pready, "pready low")

endmodule

bind hyperplane_lsh_probe_signatures_unit hlsh_checker u_hlsh_checker (.*);

[sim/hyperplane_lsh_probe_signatures_checker.sv]
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// hyperplane_lsh_probe_signatures_checker
// Watches the APB port and both channels of the probe signature unit. Keeps its
// own coefficient store, plane sums and register copies, predicts the probes
// of every finished vector and compares each accepted probe with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module hyperplane_lsh_probe_signatures_checker #(
    parameter int MAX_DIM      = 1024,
    parameter int MAX_PLANES   = 15,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    input  logic                                pready,
    // Request channel
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_mode,
    input  logic [hlsh_pkg::PLANE_WIDTH-1:0]    s_plane_index,
    input  logic [hlsh_pkg::ELEM_WIDTH-1:0]     s_element_index,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample_value,
    // Result channel
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [hlsh_pkg::SIG_WIDTH-1:0]      m_signature,
    input  logic [hlsh_pkg::NB_WIDTH-1:0]       m_probe_index,
    input  logic                                m_last_probe,
    // Status towards the stimulus side
    output int                                  mismatch_count,
    output int                                  probes_pending
);
    import hlsh_pkg::*;

    typedef struct packed {
        logic [SIG_WIDTH-1:0] signature;
        logic [NB_WIDTH-1:0]  probe_index;
        logic                 last_probe;
    } probe_t;

    logic signed [SAMPLE_WIDTH-1:0] coef_store [MAX_PLANES*MAX_DIM];
    logic [ACC_WIDTH-1:0]           plane_sum [MAX_PLANES];
    logic [DIM_WIDTH-1:0]           dimension_reg;
    logic [NB_WIDTH-1:0]            num_bits_reg;
    probe_t                         probe_queue [$];
    int                             mismatches = 0;

    // Apply one request to the model state and queue the probes it finishes
    function automatic void predict_probes(input logic mode,
                                           input logic [PLANE_WIDTH-1:0] plane,
                                           input logic [ELEM_WIDTH-1:0] elem,
                                           input logic signed [SAMPLE_WIDTH-1:0] sample);
        logic signed [ACC_WIDTH-1:0] term;
        logic [ACC_WIDTH-1:0]        base;
        logic [SIG_WIDTH-1:0]        sig;
        probe_t                      probe;
        int                          planes;
        int                          p;
        int                          k;
        if (mode == MODE_LOAD) begin
            if (plane < MAX_PLANES && elem < MAX_DIM)
                coef_store[plane*MAX_DIM + elem] = sample;
            return;
        end
        // Drop elements past the end of the vector
        if (elem >= dimension_reg || elem >= MAX_DIM)
            return;
        // Every plane gains the exact product; element zero restarts the sums
        for (p = 0; p < MAX_PLANES; p++) begin
            term = sample * coef_store[p*MAX_DIM + elem];
            base = (elem == 0) ? '0 : plane_sum[p];
            plane_sum[p] = base + term;
        end
        if (int'(elem) + 1 != int'(dimension_reg))
            return;
        // Plane count clamps into 2..MAX_PLANES
        planes = int'(num_bits_reg);
        if (planes < 2)
            planes = 2;
        if (planes > MAX_PLANES)
            planes = MAX_PLANES;
        // A bit is set only for a strictly positive sum
        sig = '0;
        for (p = 0; p < planes; p++)
            if (plane_sum[p] != '0 && !plane_sum[p][ACC_WIDTH-1])
                sig[p] = 1'b1;
        probe.signature   = sig;
        probe.probe_index = '0;
        probe.last_probe  = 1'b0;
        probe_queue.push_back(probe);
        for (k = 1; k <= planes; k++) begin
            probe.signature   = sig ^ (SIG_WIDTH'(1) << (k - 1));
            probe.probe_index = NB_WIDTH'(k);
            probe.last_probe  = (k == planes);
            probe_queue.push_back(probe);
        end
    endfunction

    always @(posedge aclk) begin
        probe_t want;
        if (!aresetn) begin
            probe_queue.delete();
            foreach (plane_sum[p])
                plane_sum[p] = '0;
            dimension_reg = DIMENSION_RESET;
            num_bits_reg  = NUM_BITS_RESET;
        end else begin
            // Compare the accepted probe with the oldest prediction
            if (m_valid && m_ready) begin
                if (probe_queue.size() == 0) begin
                    $error("unexpected probe: signature %h probe_index %0d last_probe %0b",
                           m_signature, m_probe_index, m_last_probe);
                    mismatches++;
                end else begin
                    want = probe_queue.pop_front();
                    if (m_signature !== want.signature) begin
                        $error("signature: expected %h, got %h", want.signature, m_signature);
                        mismatches++;
                    end
                    if (m_probe_index !== want.probe_index) begin
                        $error("probe_index: expected %0d, got %0d",
                               want.probe_index, m_probe_index);
                        mismatches++;
                    end
                    if (m_last_probe !== want.last_probe) begin
                        $error("last_probe: expected %0b, got %0b",
                               want.last_probe, m_last_probe);
                        mismatches++;
                    end
                end
            end
            // Predict from each accepted request
            if (s_valid && s_ready)
                predict_probes(s_mode, s_plane_index, s_element_index, s_sample_value);
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_DIMENSION: dimension_reg = pwdata[DIM_WIDTH-1:0];
                    REG_NUM_BITS:  num_bits_reg  = pwdata[NB_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
        probes_pending <= probe_queue.size();
        mismatch_count <= mismatches;
    end

endmodule

[sim/hyperplane_lsh_probe_signatures_unit_test.sv]
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// hyperplane_lsh_probe_signatures_unit_test
// Loads hyperplane coefficients and streams vector elements into the probe
// signature unit with random gaps on both channels, reprogramming dimension and
// plane count over APB between phases. The checker beside the unit predicts and
// compares every probe; this module gives the verdict.
// ----------------------------------------------------------------------------
module hyperplane_lsh_probe_signatures_unit_test;
    import hlsh_pkg::*;

    localparam int MAX_DIM         = 1024;
    localparam int MAX_PLANES      = 15;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int SETTLE_CYCLES   = 2 * (MAX_PLANES + 4);
    localparam int RANDOM_REQUESTS = 150;
    localparam int MIN_VECTORS     = 8;
    localparam int PHASE_LENGTH    = 12;
    localparam int RUN_LIMIT_NS    = 5_000_000;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic                             aclk    = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [2:0]                       paddr;
    logic [31:0]                      pwdata;
    logic [31:0]                      prdata;
    logic                             pready;
    logic                             s_valid;
    logic                             s_ready;
    logic                             s_mode;
    logic [PLANE_WIDTH-1:0]           s_plane_index;
    logic [ELEM_WIDTH-1:0]            s_element_index;
    logic signed [SAMPLE_WIDTH-1:0]   s_sample_value;
    logic                             m_valid;
    logic                             m_ready;
    logic [SIG_WIDTH-1:0]             m_signature;
    logic [NB_WIDTH-1:0]              m_probe_index;
    logic                             m_last_probe;
    int                               mismatch_count;
    int                               probes_pending;

    bit coef_written [MAX_PLANES*MAX_DIM];
    int cur_dim;
    bit tx_calm;
    bit count_requests;
    int random_requests;
    int vectors_sent;

    always #10 aclk = ~aclk;

    hyperplane_lsh_probe_signatures_unit #(
        .MAX_DIM      (MAX_DIM),
        .MAX_PLANES   (MAX_PLANES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) dut (.*);

    hyperplane_lsh_probe_signatures_checker #(
        .MAX_DIM      (MAX_DIM),
        .MAX_PLANES   (MAX_PLANES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) probe_checker (.*);

    // Favour the extremes, otherwise any value
    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    // Issue one request after a random gap and hold it until accepted
    task automatic send_request(input logic mode, input logic [PLANE_WIDTH-1:0] plane,
                                input logic [ELEM_WIDTH-1:0] elem,
                                input logic signed [SAMPLE_WIDTH-1:0] sample);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_mode          <= mode;
        s_plane_index   <= plane;
        s_element_index <= elem;
        s_sample_value  <= sample;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (count_requests && !(mode == MODE_LOAD && plane >= MAX_PLANES)
                && !(mode == MODE_VECTOR && elem >= cur_dim))
            random_requests++;
    endtask

    task automatic load_coef(input logic [PLANE_WIDTH-1:0] plane,
                             input logic [ELEM_WIDTH-1:0] elem,
                             input logic signed [SAMPLE_WIDTH-1:0] coef);
        send_request(MODE_LOAD, plane, elem, coef);
        if (plane < MAX_PLANES)
            coef_written[plane*MAX_DIM + elem] = 1'b1;
    endtask

    // Send one element; fill in any missing coefficient it would read first
    task automatic send_element(input logic [ELEM_WIDTH-1:0] elem,
                                input logic signed [SAMPLE_WIDTH-1:0] sample);
        int p;
        if (elem < cur_dim)
            for (p = 0; p < MAX_PLANES; p++)
                if (!coef_written[p*MAX_DIM + elem])
                    load_coef(PLANE_WIDTH'(p), elem, pick_sample());
        send_request(MODE_VECTOR, PLANE_WIDTH'($urandom_range(0, 15)), elem, sample);
    endtask

    task automatic send_vector(input int len);
        int e;
        for (e = 0; e < len; e++)
            send_element(ELEM_WIDTH'(e), pick_sample());
    endtask

    // Hold off until every predicted probe is out and the chain is empty
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (probes_pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int dim, input int planes);
        drain();
        apb_write(REG_DIMENSION, 32'(dim));
        apb_write(REG_NUM_BITS, 32'(planes));
        cur_dim = dim;
    endtask

    // Result side: random stalls, with calm stretches now and then
    initial begin
        int stall;
        int served;
        bit calm;
        m_ready = 1'b0;
        served  = 0;
        calm    = 1'b0;
        wait (aresetn);
        forever begin
            if (served % 24 == 0)
                calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, 6);
            @(negedge aclk);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            served++;
        end
    end

    // Stimulus
    initial begin
        int p;
        int e;
        int iter;
        int kind;
        int len;
        s_valid         = 1'b0;
        s_mode          = MODE_LOAD;
        s_plane_index   = '0;
        s_element_index = '0;
        s_sample_value  = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        tx_calm         = 1'b0;
        count_requests  = 1'b0;
        random_requests = 0;
        vectors_sent    = 0;
        cur_dim         = int'(DIMENSION_RESET);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // One-element vectors over all fifteen planes, extreme coefficients
        configure(1, 15);
        for (p = 0; p < MAX_PLANES; p++)
            case (p % 4)
                0: load_coef(PLANE_WIDTH'(p), '0, SAMPLE_MAX);
                1: load_coef(PLANE_WIDTH'(p), '0, SAMPLE_MIN);
                2: load_coef(PLANE_WIDTH'(p), '0, '0);
                default: load_coef(PLANE_WIDTH'(p), '0, -1);
            endcase
        // Load to the plane past the last one is dropped
        load_coef(PLANE_WIDTH'(MAX_PLANES), ELEM_WIDTH'(MAX_DIM - 1), SAMPLE_MIN);
        send_element('0, SAMPLE_MAX);
        send_element('0, SAMPLE_MIN);
        send_element('0, '0);
        send_element('0, 1);
        send_element(ELEM_WIDTH'(MAX_DIM - 1), SAMPLE_MAX);

        // Longest vector with its middle skipped; plane count below the floor
        configure(MAX_DIM, 0);
        send_element('0, -1);
        send_element(ELEM_WIDTH'(MAX_DIM - 1), SAMPLE_MAX);

        // Dimensions that never finish a vector
        configure(0, 1);
        send_element('0, SAMPLE_MAX);
        send_element(ELEM_WIDTH'(MAX_DIM - 1), SAMPLE_MIN);
        configure((1 << DIM_WIDTH) - 1, 2);
        send_element('0, SAMPLE_MIN);
        send_element(ELEM_WIDTH'(MAX_DIM - 1), 1);

        // Random phases: mostly whole vectors, some broken ones and noise
        count_requests = 1'b1;
        iter = 0;
        while (random_requests < RANDOM_REQUESTS || vectors_sent < MIN_VECTORS) begin
            if (iter % PHASE_LENGTH == 0) begin
                configure(($urandom_range(0, 4) == 0) ? $urandom_range(13, 16)
                                                      : $urandom_range(1, 12),
                          $urandom_range(0, 15));
                tx_calm = ($urandom_range(0, 2) == 0);
            end
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                send_vector(cur_dim);
                vectors_sent++;
            end else if (kind == 7) begin
                // Cut short, then jump to any element of the vector
                len = $urandom_range(1, cur_dim);
                for (e = 0; e < len - 1; e++)
                    send_element(ELEM_WIDTH'(e), pick_sample());
                send_element(ELEM_WIDTH'($urandom_range(0, cur_dim - 1)), pick_sample());
            end else if (kind == 8) begin
                load_coef(PLANE_WIDTH'($urandom_range(0, 15)),
                          ELEM_WIDTH'($urandom_range(0, MAX_DIM - 1)), pick_sample());
            end else begin
                send_element(ELEM_WIDTH'($urandom_range(0, MAX_DIM - 1)), pick_sample());
            end
            iter++;
        end
        count_requests = 1'b0;

        drain();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
